[rtl/murmur2_hash_with_bucket_macros.svh]
// Assertion macros shared by the hash block
`ifndef MURMUR2_HASH_WITH_BUCKET_MACROS_SVH
`define MURMUR2_HASH_WITH_BUCKET_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge out of reset
`define MM2_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mm2 assertion failed");
// Check that a signal is unchanged in the cycle after a condition
`define MM2_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("mm2 hold assertion failed");
`else
`define MM2_ASSERT(lbl, clk, rstn, prop)
`define MM2_ASSERT_HOLD(lbl, clk, rstn, cond, sig)
`endif

`endif

[rtl/mm2_pkg.sv]
package mm2_pkg;

  // Input word: one byte of a message
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        is_last;
    logic        no_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [31:0] hash_value;
    logic [7:0]  bucket;
    logic        length_mismatch;
  } out_word_t;

  // Queue entry: input word plus front classification
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        is_last;
    logic        no_byte;
    logic        first;
  } mm2_item_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRD_SHF,
    ST_WRD_ACC,
    ST_WRD_FOLD,
    ST_FIN_TAIL,
    ST_FIN_TAKE,
    ST_FIN_MIX,
    ST_FIN_END,
    ST_BKT_MUL,
    ST_BKT_V4,
    ST_BKT_A,
    ST_BKT_B0,
    ST_BKT_B2,
    ST_DONE
  } mm2_state_e;

  // Register map
  localparam int unsigned APB_AW = 3;
  localparam logic [0:0]  REG_HASH_SEED = 1'b0;
  localparam logic [31:0] SEED_RESET = 32'hBAADFEED;

  // Input queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // Mixing constants
  localparam logic [31:0] MIX_M      = 32'h5BD1E995;
  localparam logic [31:0] BKT_MUL_T  = 32'd4097;
  localparam logic [31:0] BKT_ADD_T  = 32'd2127912214;
  localparam logic [31:0] BKT_XOR_V4 = 32'hC761C23C;
  localparam logic [31:0] BKT_MUL_V  = 32'd33;
  localparam logic [31:0] BKT_ADD_V5 = 32'd374761393;
  localparam logic [31:0] BKT_SUB_A  = 32'd369570787;
  localparam logic [31:0] BKT_MUL_A  = 32'd9;
  localparam logic [31:0] BKT_SUB_A2 = 32'd42973499;
  localparam logic [31:0] BKT_XOR_B  = 32'hB55A4F09;
  localparam logic [31:0] BKT_ADD_B0 = 32'd29;
  localparam logic [31:0] BKT_SUB_B0 = 32'd59;
  localparam logic [31:0] BKT_SUB_W2 = 32'd13283;
  localparam logic [31:0] BKT_ADD_W2 = 32'd18117;
  localparam logic [31:0] BKT_XOR_W2 = 32'h00004F09;
  localparam logic [7:0]  BKT_XOR_OUT = 8'd9;

endpackage

[rtl/mm2_front.sv]
`include "murmur2_hash_with_bucket_macros.svh"

module mm2_front import mm2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      q_valid_o,
  output mm2_item_t q_item_o,
  input  logic      q_pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  mm2_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             open_q;
  logic             push;
  mm2_item_t        item;

  assign in_stall_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Tag the word that opens a message
  always_comb begin
    item.data_byte      = in_word_i.data_byte;
    item.message_length = in_word_i.message_length;
    item.is_last        = in_word_i.is_last;
    item.no_byte        = in_word_i.no_byte;
    item.first          = !open_q;
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  // Advance pointers, count and message tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      open_q   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
        open_q   <= !in_word_i.is_last;
      end
      if (q_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push && q_pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `MM2_ASSERT(a_cnt_max, clk_i, rst_ni, count_q <= CNT_W'(QUEUE_DEPTH))
  `MM2_ASSERT(a_cnt_push, clk_i, rst_ni, push && !q_pop_i |=> count_q == $past(count_q) + 1'b1)
  `MM2_ASSERT_HOLD(a_open_hold, clk_i, rst_ni, !push, open_q)

endmodule

[rtl/mm2_back.sv]
`include "murmur2_hash_with_bucket_macros.svh"

module mm2_back import mm2_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  mm2_item_t   q_item_i,
  output logic        q_pop_o,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  localparam logic [LENGTH_BITS-1:0] SEEN_MAX = {LENGTH_BITS{1'b1}};

  mm2_state_e             st_q, st_d;
  logic [31:0]            acc_q, acc_d;
  logic [23:0]            part_q, part_d;
  logic [1:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] seen_q, seen_d;
  logic [LENGTH_BITS-1:0] decl_q, decl_d;
  logic                   last_q, last_d;
  logic [31:0]            prod_q, prod_d;
  logic [31:0]            k_q, k_d;
  logic [31:0]            h_q, h_d;
  logic [31:0]            p33_q, p33_d;
  logic [31:0]            v5_q, v5_d;
  logic [31:0]            a_q, a_d;
  logic [7:0]             b0_q, b0_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;

  logic [31:0]            mul_a, mul_b, mul_p;
  logic                   slot_free;
  logic [31:0]            len32;
  logic [31:0]            acc_b;
  logic [23:0]            part_b;
  logic [1:0]             phase_b;
  logic [LENGTH_BITS-1:0] seen_b;
  logic [31:0]            t_v, v4_v, v5_v, a_hi, b_v, w2_v;
  logic [7:0]             bucket_v;

  // Shared multiplier, result registered in prod_q
  assign mul_p = mul_a * mul_b;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (st_q == ST_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign len32       = 32'(q_item_i.message_length);

  // Sequence one item: byte packing, word mix, finalization, bucket
  always_comb begin
    st_d        = st_q;
    acc_d       = acc_q;
    part_d      = part_q;
    phase_d     = phase_q;
    seen_d      = seen_q;
    decl_d      = decl_q;
    last_d      = last_q;
    prod_d      = prod_q;
    k_d         = k_q;
    h_d         = h_q;
    p33_d       = p33_q;
    v5_d        = v5_q;
    a_d         = a_q;
    b0_d        = b0_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = '0;
    mul_b       = MIX_M;

    // Start of message restarts the running state
    if (q_item_i.first) begin
      acc_b   = seed_i ^ 32'(len32[LENGTH_BITS-1:0]);
      part_b  = '0;
      phase_b = 2'd0;
      seen_b  = '0;
    end else begin
      acc_b   = acc_q;
      part_b  = part_q;
      phase_b = phase_q;
      seen_b  = seen_q;
    end

    // Bucket mixing terms
    t_v      = prod_q + BKT_ADD_T;
    v4_v     = t_v ^ (t_v >> 19) ^ BKT_XOR_V4;
    v5_v     = (prod_q + BKT_ADD_V5) << 9;
    a_hi     = {16'h0000, a_q[31:16]};
    b_v      = a_hi ^ a_q ^ BKT_XOR_B;
    w2_v     = a_hi ^ (prod_q + BKT_ADD_W2) ^ BKT_XOR_W2 ^ (b_v >> 16);
    bucket_v = b0_q ^ BKT_XOR_OUT ^ b_v[23:16] ^ w2_v[15:8];

    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          acc_d   = acc_b;
          part_d  = part_b;
          phase_d = phase_b;
          seen_d  = seen_b;
          last_d  = q_item_i.is_last;
          if (q_item_i.first) begin
            decl_d = len32[LENGTH_BITS-1:0];
          end
          if (!q_item_i.no_byte) begin
            seen_d = (seen_b != SEEN_MAX) ? seen_b + 1'b1 : seen_b;
            if (phase_b != 2'd3) begin
              part_d  = part_b | (24'(q_item_i.data_byte) << {phase_b, 3'b000});
              phase_d = phase_b + 2'd1;
            end else begin
              // Fourth byte completes a word
              mul_a   = {q_item_i.data_byte, part_b};
              prod_d  = mul_p;
              part_d  = '0;
              phase_d = 2'd0;
              st_d    = ST_WRD_SHF;
            end
          end
          if (st_d == ST_IDLE && q_item_i.is_last) begin
            st_d = ST_FIN_TAIL;
          end
        end
      end
      ST_WRD_SHF: begin
        mul_a  = prod_q ^ (prod_q >> 24);
        prod_d = mul_p;
        st_d   = ST_WRD_ACC;
      end
      ST_WRD_ACC: begin
        k_d    = prod_q;
        mul_a  = acc_q;
        prod_d = mul_p;
        st_d   = ST_WRD_FOLD;
      end
      ST_WRD_FOLD: begin
        acc_d = prod_q ^ k_q;
        st_d  = last_q ? ST_FIN_TAIL : ST_IDLE;
      end
      ST_FIN_TAIL: begin
        if (phase_q != 2'd0) begin
          mul_a  = acc_q ^ {8'h00, part_q};
          prod_d = mul_p;
          st_d   = ST_FIN_TAKE;
        end else begin
          h_d  = acc_q;
          st_d = ST_FIN_MIX;
        end
      end
      ST_FIN_TAKE: begin
        h_d  = prod_q;
        st_d = ST_FIN_MIX;
      end
      ST_FIN_MIX: begin
        mul_a  = h_q ^ (h_q >> 13);
        prod_d = mul_p;
        st_d   = ST_FIN_END;
      end
      ST_FIN_END: begin
        h_d   = prod_q ^ (prod_q >> 15);
        acc_d = prod_q ^ (prod_q >> 15);
        st_d  = ST_BKT_MUL;
      end
      ST_BKT_MUL: begin
        mul_a  = h_q;
        mul_b  = BKT_MUL_T;
        prod_d = mul_p;
        st_d   = ST_BKT_V4;
      end
      ST_BKT_V4: begin
        mul_a  = v4_v;
        mul_b  = BKT_MUL_V;
        prod_d = mul_p;
        st_d   = ST_BKT_A;
      end
      ST_BKT_A: begin
        p33_d  = prod_q;
        v5_d   = v5_v;
        mul_a  = v5_v ^ (prod_q - BKT_SUB_A);
        mul_b  = BKT_MUL_A;
        prod_d = mul_p;
        st_d   = ST_BKT_B0;
      end
      ST_BKT_B0: begin
        a_d    = prod_q - BKT_SUB_A2;
        mul_a  = v5_q ^ (p33_q + BKT_ADD_B0);
        mul_b  = BKT_MUL_A;
        prod_d = mul_p;
        st_d   = ST_BKT_B2;
      end
      ST_BKT_B2: begin
        b0_d   = a_hi[7:0] ^ (prod_q[7:0] - BKT_SUB_B0[7:0]);
        mul_a  = v5_q ^ (p33_q - BKT_SUB_W2);
        mul_b  = BKT_MUL_A;
        prod_d = mul_p;
        st_d   = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (slot_free) begin
          out_d.hash_value      = h_q;
          out_d.bucket          = bucket_v;
          out_d.length_mismatch = (seen_q != decl_q);
          out_valid_d           = 1'b1;
          part_d                = '0;
          phase_d               = 2'd0;
          st_d                  = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      part_q      <= '0;
      phase_q     <= 2'd0;
      seen_q      <= '0;
      decl_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      part_q      <= part_d;
      phase_q     <= phase_d;
      seen_q      <= seen_d;
      decl_q      <= decl_d;
      last_q      <= last_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    k_q    <= k_d;
    h_q    <= h_d;
    p33_q  <= p33_d;
    v5_q   <= v5_d;
    a_q    <= a_d;
    b0_q   <= b0_d;
    out_q  <= out_d;
  end

  `MM2_ASSERT(a_word_clears, clk_i, rst_ni, st_q == ST_WRD_SHF |-> phase_q == 2'd0 && part_q == '0)
  `MM2_ASSERT(a_done_emit, clk_i, rst_ni, $past(st_q) == ST_DONE && st_q == ST_IDLE |-> out_valid_q)
  `MM2_ASSERT_HOLD(a_done_wait, clk_i, rst_ni, st_q == ST_DONE && out_valid_q && out_stall_i, st_q)

endmodule

[rtl/murmur2_hash_with_bucket.sv]
// MurmurHash2 (32-bit) over a byte stream, with an 8-bit bucket index. Send one byte
// per word; the first word of a message also carries the declared length, and the
// word marked is_last produces one result (hash, bucket, length mismatch flag). An
// empty message is a single word with no_byte and is_last set. Input words pass a
// two-entry queue into a sequencer built around one shared 32x32 multiplier. A byte
// that does not complete a 4-byte word is absorbed in the idle state, a byte that
// completes one passes through the word-mix states, and the last word then runs
// finalization and bucket mixing before the result enters the output register.
// hash_seed lies at address 0 and must only be written while no message is in flight.
module murmur2_hash_with_bucket import mm2_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] seed_q;
  logic        q_valid;
  logic        q_pop;
  mm2_item_t   q_item;
  logic        seed_sel;

  // Register decode
  assign seed_sel = (paddr[APB_AW-1:2] == REG_HASH_SEED);
  assign pready   = 1'b1;
  assign prdata   = seed_sel ? seed_q : '0;

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed_q <= pwdata;
    end
  end

  mm2_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mm2_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .seed_i      (seed_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[sim/murmur2_hash_with_bucket_checker.sv]
module murmur2_hash_with_bucket_checker import mm2_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_word_t          in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_word_t         out_word_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [APB_AW-1:0] SEED_ADDR   = APB_AW'(4 * REG_HASH_SEED);
  localparam logic [31:0]       SEED_AT_RST = 32'hBAADFEED;
  localparam logic [31:0]       MULT        = 32'h5BD1E995;

  // Running hash of the open message
  logic [31:0] seed_q;
  logic [31:0] acc_q;
  logic [23:0] tail_q;
  logic [1:0]  tail_cnt_q;
  logic [15:0] byte_cnt_q;
  logic [15:0] decl_len_q;
  logic        open_q;

  out_word_t pending_hashes[$];
  int        errors = 0;

  // Fixed bucket scramble of a finished hash
  function automatic logic [7:0] bucket_mix(input logic [31:0] h);
    logic [31:0] t, v4, v5, a, b, b0, b1, w2;
    t  = 32'd4097 * h + 32'd2127912214;
    v4 = t ^ (t >> 19) ^ 32'hC761C23C;
    v5 = (32'd33 * v4 + 32'd374761393) << 9;
    a  = 32'd9 * (v5 ^ (32'd33 * v4 - 32'd369570787)) - 32'd42973499;
    b  = (a >> 16) ^ a ^ 32'hB55A4F09;
    b0 = (a >> 16) ^ (32'd9 * (v5 ^ (32'd33 * v4 + 32'd29)) - 32'd59);
    b1 = b >> 16;
    w2 = ((a >> 16) ^ (32'd9 * (v5 ^ (32'd33 * v4 - 32'd13283)) + 32'd18117)
          ^ 32'h00004F09 ^ (b >> 16)) & 32'h0000FFFF;
    return b0[7:0] ^ 8'd9 ^ b1[7:0] ^ w2[15:8];
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    out_word_t   want;
    logic [31:0] k;
    logic [31:0] h;
    if (!rst_ni) begin
      seed_q     = SEED_AT_RST;
      acc_q      = '0;
      tail_q     = '0;
      tail_cnt_q = '0;
      byte_cnt_q = '0;
      decl_len_q = '0;
      open_q     = 1'b0;
      pending_hashes.delete();
      pending_o    = 0;
      fail_count_o = errors;
    end else begin
      // Track the seed register and check read-back
      if (psel_i && penable_i && pready_i && paddr_i == SEED_ADDR) begin
        if (pwrite_i) begin
          seed_q = pwdata_i;
        end else begin
          compare_field("hash_seed read", seed_q, prdata_i);
        end
      end

      // Compare a delivered result word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_hashes.size() == 0) begin
          $display("%0t: result word with nothing expected: got %h", $time, out_word_i);
          errors++;
        end else begin
          want = pending_hashes.pop_front();
          compare_field("hash_value", want.hash_value, out_word_i.hash_value);
          compare_field("bucket", 32'(want.bucket), 32'(out_word_i.bucket));
          compare_field("length_mismatch", 32'(want.length_mismatch),
                        32'(out_word_i.length_mismatch));
        end
      end

      // Absorb an accepted input word
      if (in_valid_i && !in_stall_i) begin
        if (!open_q) begin
          decl_len_q = in_word_i.message_length;
          acc_q      = seed_q ^ {16'h0000, in_word_i.message_length};
          tail_q     = '0;
          tail_cnt_q = '0;
          byte_cnt_q = '0;
          open_q     = 1'b1;
        end
        if (!in_word_i.no_byte) begin
          if (tail_cnt_q != 2'd3) begin
            tail_q     = tail_q | (24'(in_word_i.data_byte) << (8 * tail_cnt_q));
            tail_cnt_q = tail_cnt_q + 2'd1;
          end else begin
            // Mix a full little-endian word into the hash
            k     = {in_word_i.data_byte, tail_q};
            k     = k * MULT;
            k     = k ^ (k >> 24);
            k     = k * MULT;
            acc_q = (acc_q * MULT) ^ k;
            tail_q     = '0;
            tail_cnt_q = '0;
          end
          // Saturate the byte count
          if (byte_cnt_q != 16'hFFFF) begin
            byte_cnt_q = byte_cnt_q + 16'd1;
          end
        end
        if (in_word_i.is_last) begin
          // Fold the tail and finalize
          h = acc_q;
          if (tail_cnt_q != 2'd0) begin
            h = h ^ {8'h00, tail_q};
            h = h * MULT;
          end
          h = h ^ (h >> 13);
          h = h * MULT;
          h = h ^ (h >> 15);
          want.hash_value      = h;
          want.bucket          = bucket_mix(h);
          want.length_mismatch = (byte_cnt_q != decl_len_q);
          pending_hashes.push_back(want);
          open_q     = 1'b0;
          acc_q      = h;
          tail_q     = '0;
          tail_cnt_q = '0;
        end
      end

      pending_o    = pending_hashes.size();
      fail_count_o = errors;
    end
  end

endmodule

[sim/murmur2_hash_with_bucket_test.sv]
module murmur2_hash_with_bucket_test;
  import mm2_pkg::*;

  localparam logic [APB_AW-1:0] SEED_ADDR       = APB_AW'(4 * REG_HASH_SEED);
  localparam int                QUIET_LIMIT     = 5000;
  localparam int                HOLD_OFF_CYCLES = 400;
  localparam int                DRAIN_CYCLES    = 40;
  localparam int                PHASE_WORDS     = 200;
  localparam int                RANDOM_FILL     = -1;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_word_t          in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_word_t         out_word_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int words_sent      = 0;
  int burst_left      = 0;
  int holdoffs_wanted = 0;
  int holdoffs_done   = 0;

  murmur2_hash_with_bucket dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  murmur2_hash_with_bucket_checker hash_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  // Offer one word, in bursts with random gaps, and hold it until taken
  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Send one message: nbytes bytes, optional holes, optional byteless end word
  task automatic send_message(input logic [15:0] decl, input int nbytes, input int hole_pct,
                              input bit end_marker, input int fill);
    in_word_t w;
    int       left;
    bit       first;
    left  = nbytes;
    first = 1'b1;
    do begin
      w.no_byte        = (left == 0) || ($urandom_range(99) < hole_pct);
      w.data_byte      = (fill < 0) ? 8'($urandom) : 8'(fill);
      w.message_length = first ? decl : 16'($urandom);
      if (!w.no_byte) left--;
      w.is_last = w.no_byte ? (left == 0) : (left == 0 && !end_marker);
      first = 1'b0;
      send_word(w);
    end while (!w.is_last);
  endtask

  // Drop valid and wait for the block to drain completely
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic seed_access(input logic write, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed messages, some with wrong lengths, some empty
  task automatic random_phase(input int target);
    int          stop_at;
    int          kind;
    int          n;
    logic [15:0] decl;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      kind = $urandom_range(99);
      n    = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (kind < 75) begin
        send_message(16'(n), n, 8, $urandom_range(4) == 0, RANDOM_FILL);
      end else if (kind < 90) begin
        decl = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(n + $urandom_range(4) - 2);
        send_message(decl, n, 8, $urandom_range(4) == 0, RANDOM_FILL);
      end else begin
        decl = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
        send_message(decl, 0, 0, 1'b0, RANDOM_FILL);
      end
    end
  endtask

  // Receiver stall pattern, with long hold-offs on request
  initial begin : receiver
    stall_mode_e mode;
    int          mode_left;
    mode      = STALL_NONE;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoffs_done < holdoffs_wanted) begin
        holdoffs_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(2));
          mode_left = $urandom_range(1, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE: begin
            out_stall_i <= 1'b0;
          end
          STALL_HALF: begin
            out_stall_i <= ($urandom_range(1) == 0);
          end
          default: begin
            out_stall_i <= ($urandom_range(3) != 0);
          end
        endcase
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[murmur2_hash_with_bucket] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] seeds[5];
    seeds[0] = 32'h00000000;
    seeds[1] = 32'hFFFFFFFF;
    seeds[2] = $urandom;
    seeds[3] = $urandom;
    seeds[4] = $urandom;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Check the seed after reset
    seed_access(1'b0, 32'h0);

    // Directed: empty messages, edge bytes, tails, holes, wrong lengths
    send_message(16'd0, 0, 0, 1'b0, RANDOM_FILL);
    send_message(16'hFFFF, 0, 0, 1'b0, RANDOM_FILL);
    send_message(16'd1, 1, 0, 1'b0, 8'hFF);
    send_message(16'd3, 3, 0, 1'b0, 8'h00);
    send_message(16'd4, 4, 0, 1'b1, 8'hFF);
    send_message(16'd6, 6, 40, 1'b1, RANDOM_FILL);
    send_message(16'd0, 2, 0, 1'b0, RANDOM_FILL);
    send_message(16'd7, 3, 0, 1'b0, 8'hFF);
    wait_idle();

    // Random phases, one per seed; squeeze the output in one of them
    foreach (seeds[i]) begin
      seed_access(1'b1, seeds[i]);
      seed_access(1'b0, 32'h0);
      if (i == 2) holdoffs_wanted++;
      random_phase(PHASE_WORDS);
      wait_idle();
    end

    // Long message with a declared length far above its byte count
    seed_access(1'b1, $urandom);
    send_message(16'hFFFF, 64, 0, 1'b0, RANDOM_FILL);
    send_message(16'd5, 5, 0, 1'b0, RANDOM_FILL);
    wait_idle();

    if (fail_count == 0) begin
      $display("[murmur2_hash_with_bucket] OK");
    end else begin
      $display("[murmur2_hash_with_bucket] ERROR");
    end
    $finish;
  end

endmodule
